// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define SCF_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define SCF_ASSERT(lbl, clk, rstn, prop)
`define SCF_ASSERT_NEXT(lbl, clk, rstn, cond, prop)
`endif
`endif

// ----- rtl/core/scf_pkg.sv -----
// ----------------------------------------------------------------------------
// scf_pkg
// Sizes and codes shared by the strong component finder.
// ----------------------------------------------------------------------------
package scf_pkg;
    localparam int MAX_NODES = 256;
    localparam int MAX_EDGES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int EADDR_W   = $clog2(MAX_EDGES);
    localparam int EPTR_W    = EADDR_W + 1;
    localparam logic [EPTR_W-1:0] EDGE_NULL = EPTR_W'(MAX_EDGES);

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_ADD     = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;
    localparam logic [1:0] ACT_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_ALL_COMP   = 1'b1;
endpackage

// ----- rtl/core/strong_component_finder_top.sv -----
// ----------------------------------------------------------------------------
// strong_component_finder_top
// Stores a directed graph and finds its strongly connected components with
// a path-based depth-first search held in on-chip memories.
//
// The input channel (s_valid/s_ready) takes one word per action: clear,
// add edge, compute or query. Every word yields exactly one result word on
// the output channel (m_valid/m_ready). The node count and the
// all-components flag are to be written by the user over the APB port
// only while the block idles; the block itself does not enforce this. A
// compute scans the nodes from 1 up to the node count, enters each node
// not yet seen, follows its edges, pops the boundary stack and closes
// each root by marking its members; its pace is bounded by the single
// read port of each memory. One word is processed at a time; s_ready is
// high whenever the sequencer is idle, even while a result waits. A
// stalled receiver holds the result register and delays only the next
// result.
// Reset empties the edge store and the recorded components and clears the
// registers; it needs no clearing pass.
// ----------------------------------------------------------------------------
module strong_component_finder_top (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_action,
    input  logic [scf_pkg::NODE_W-1:0] s_node,
    input  logic [scf_pkg::NODE_W-1:0] s_dest_node,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic [scf_pkg::CNT_W-1:0]  m_component_count,
    output logic                     m_node_listed,
    output logic                     m_node_cyclic,
    output logic [scf_pkg::NODE_W-1:0] m_component_id
);
    import scf_pkg::*;
    `include "assert_macros.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADD2  = 4'd1;
    localparam logic [3:0] S_QRY2  = 4'd2;
    localparam logic [3:0] S_OUTER = 4'd3;
    localparam logic [3:0] S_ENTER = 4'd4;
    localparam logic [3:0] S_ENT2  = 4'd5;
    localparam logic [3:0] S_LOOP  = 4'd6;
    localparam logic [3:0] S_EDGE2 = 4'd7;
    localparam logic [3:0] S_NODE2 = 4'd8;
    localparam logic [3:0] S_BPOP  = 4'd9;
    localparam logic [3:0] S_BPOP2 = 4'd10;
    localparam logic [3:0] S_POP2  = 4'd11;
    localparam logic [3:0] S_CLRD  = 4'd12;
    localparam logic [3:0] S_CLWR  = 4'd13;
    localparam logic [3:0] S_EMIT  = 4'd14;

    localparam int FRAME_W = NODE_W + EPTR_W;
    localparam int EDGE_W  = EPTR_W + NODE_W;

    logic [EPTR_W-1:0]  head_mem  [MAX_NODES];
    logic [EDGE_W-1:0]  edge_mem  [MAX_EDGES];
    logic [NODE_W:0]    node_mem  [MAX_NODES];
    logic [NODE_W:0]    comp_mem  [MAX_NODES];
    logic [NODE_W-1:0]  path_mem  [MAX_NODES];
    logic [NODE_W-1:0]  bound_mem [MAX_NODES];
    logic [FRAME_W-1:0] frame_mem [MAX_NODES];

    logic                head_we, edge_we, node_we, comp_we, path_we, bound_we, frame_we;
    logic [NODE_W-1:0]   head_waddr, node_waddr, comp_waddr, path_waddr;
    logic [NODE_W-1:0]   bound_waddr, frame_waddr;
    logic [EADDR_W-1:0]  edge_waddr, edge_raddr;
    logic [NODE_W-1:0]   head_raddr, node_raddr, comp_raddr, path_raddr;
    logic [NODE_W-1:0]   bound_raddr, frame_raddr;
    logic [EPTR_W-1:0]   head_wdata, head_rdata;
    logic [EDGE_W-1:0]   edge_wdata, edge_rdata;
    logic [NODE_W:0]     node_wdata, node_rdata, comp_wdata, comp_rdata;
    logic [NODE_W-1:0]   path_wdata, path_rdata, bound_wdata, bound_rdata;
    logic [FRAME_W-1:0]  frame_wdata, frame_rdata;

    logic [3:0]           state_reg, state_next;
    logic [CNT_W-1:0]     sp_reg, sp_next, bp_reg, bp_next, fp_reg, fp_next;
    logic [CNT_W-1:0]     v_reg, v_next, i_reg, i_next, rec_reg, rec_next;
    logic [NODE_W-1:0]    w_reg, w_next, ot_reg, ot_next, base_reg, base_next;
    logic [NODE_W-1:0]    top_node_reg, top_node_next, a_reg, a_next, b_reg, b_next;
    logic [EPTR_W-1:0]    top_edge_reg, top_edge_next, etot_reg, etot_next;
    logic                 keep_reg, keep_next, cyc_reg, cyc_next;
    logic [MAX_NODES-1:0] head_vld_reg, head_vld_next, node_vld_reg, node_vld_next;
    logic [MAX_NODES-1:0] comp_vld_reg, comp_vld_next;
    logic [1:0]           pst_reg, pst_next;
    logic                 plst_reg, plst_next, pcyc_reg, pcyc_next;
    logic [NODE_W-1:0]    pid_reg, pid_next;
    logic                 mv_reg, mv_next;
    logic [1:0]           mst_reg, mst_next;
    logic [CNT_W-1:0]     mcnt_reg, mcnt_next;
    logic                 mlst_reg, mlst_next, mcyc_reg, mcyc_next;
    logic [NODE_W-1:0]    mid_reg, mid_next;
    logic [NODE_W-1:0]    nc_reg;
    logic                 allc_reg;
    logic [CNT_W-1:0]     size;
    logic [NODE_W-1:0]    tgt;

    function automatic logic in_range(input logic [NODE_W-1:0] x, input logic [NODE_W-1:0] n);
        in_range = (x != '0) && (x <= n);
    endfunction

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_waddr] <= head_wdata;
        head_rdata <= head_mem[head_raddr];
    end
    always_ff @(posedge aclk) begin
        if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
        edge_rdata <= edge_mem[edge_raddr];
    end
    always_ff @(posedge aclk) begin
        if (node_we) node_mem[node_waddr] <= node_wdata;
        node_rdata <= node_mem[node_raddr];
    end
    always_ff @(posedge aclk) begin
        if (comp_we) comp_mem[comp_waddr] <= comp_wdata;
        comp_rdata <= comp_mem[comp_raddr];
    end
    always_ff @(posedge aclk) begin
        if (path_we) path_mem[path_waddr] <= path_wdata;
        path_rdata <= path_mem[path_raddr];
    end
    always_ff @(posedge aclk) begin
        if (bound_we) bound_mem[bound_waddr] <= bound_wdata;
        bound_rdata <= bound_mem[bound_raddr];
    end
    always_ff @(posedge aclk) begin
        if (frame_we) frame_mem[frame_waddr] <= frame_wdata;
        frame_rdata <= frame_mem[frame_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_reg   <= '0;
            allc_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_NODE_COUNT) begin
                nc_reg <= pwdata[NODE_W-1:0];
            end else begin
                allc_reg <= pwdata[0];
            end
        end
    end

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_ALL_COMP) ? {31'd0, allc_reg}
                                                : {{(32-NODE_W){1'b0}}, nc_reg};
    assign s_ready = (state_reg == S_IDLE);
    assign size    = sp_reg - {1'b0, node_rdata[NODE_W-1:0]};
    assign tgt     = edge_rdata[NODE_W-1:0];

    always_comb begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        bp_next       = bp_reg;
        fp_next       = fp_reg;
        v_next        = v_reg;
        i_next        = i_reg;
        rec_next      = rec_reg;
        w_next        = w_reg;
        ot_next       = ot_reg;
        base_next     = base_reg;
        top_node_next = top_node_reg;
        top_edge_next = top_edge_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        etot_next     = etot_reg;
        keep_next     = keep_reg;
        cyc_next      = cyc_reg;
        head_vld_next = head_vld_reg;
        node_vld_next = node_vld_reg;
        comp_vld_next = comp_vld_reg;
        pst_next      = pst_reg;
        plst_next     = plst_reg;
        pcyc_next     = pcyc_reg;
        pid_next      = pid_reg;
        mv_next       = mv_reg && !m_ready;
        mst_next      = mst_reg;
        mcnt_next     = mcnt_reg;
        mlst_next     = mlst_reg;
        mcyc_next     = mcyc_reg;
        mid_next      = mid_reg;
        head_we = 1'b0; edge_we = 1'b0; node_we = 1'b0; comp_we = 1'b0;
        path_we = 1'b0; bound_we = 1'b0; frame_we = 1'b0;
        head_waddr = a_reg;            head_wdata = etot_reg;
        edge_waddr = etot_reg[EADDR_W-1:0];
        edge_wdata = {(head_vld_reg[a_reg] ? head_rdata : EDGE_NULL), b_reg};
        node_waddr = w_reg;            node_wdata = {1'b0, sp_reg[NODE_W-1:0]};
        comp_waddr = path_rdata;       comp_wdata = {cyc_reg, rec_reg[NODE_W-1:0]};
        path_waddr = sp_reg[NODE_W-1:0]; path_wdata = w_reg;
        bound_waddr = bp_reg[NODE_W-1:0]; bound_wdata = sp_reg[NODE_W-1:0];
        frame_waddr = NODE_W'(fp_reg - 1'b1); frame_wdata = {top_node_reg, top_edge_reg};
        head_raddr = w_reg;
        edge_raddr = top_edge_reg[EADDR_W-1:0];
        node_raddr = top_node_reg;
        comp_raddr = a_reg;
        path_raddr = i_reg[NODE_W-1:0];
        bound_raddr = NODE_W'(bp_reg - 1'b1);
        frame_raddr = NODE_W'(fp_reg - 2'd2);

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    a_next    = s_node;
                    b_next    = s_dest_node;
                    pst_next  = ST_OK;
                    plst_next = 1'b0;
                    pcyc_next = 1'b0;
                    pid_next  = '0;
                    state_next = S_EMIT;
                    case (s_action)
                        ACT_CLEAR: begin
                            head_vld_next = '0;
                            comp_vld_next = '0;
                            etot_next     = '0;
                            rec_next      = '0;
                        end
                        ACT_ADD: begin
                            if (!in_range(s_node, nc_reg) || !in_range(s_dest_node, nc_reg)) begin
                                pst_next = ST_RANGE;
                            end else if (etot_reg[EADDR_W]) begin
                                pst_next = ST_FULL;
                            end else begin
                                head_raddr = s_node;
                                state_next = S_ADD2;
                            end
                        end
                        ACT_COMPUTE: begin
                            node_vld_next = '0;
                            comp_vld_next = '0;
                            rec_next      = '0;
                            sp_next       = '0;
                            bp_next       = '0;
                            fp_next       = '0;
                            v_next        = CNT_W'(1);
                            state_next    = S_OUTER;
                        end
                        default: begin
                            if (!in_range(s_node, nc_reg)) begin
                                pst_next = ST_RANGE;
                            end else begin
                                comp_raddr = s_node;
                                state_next = S_QRY2;
                            end
                        end
                    endcase
                end
            end
            S_ADD2: begin
                edge_we = 1'b1;
                head_we = 1'b1;
                head_vld_next[a_reg] = 1'b1;
                etot_next  = etot_reg + 1'b1;
                state_next = S_EMIT;
            end
            S_QRY2: begin
                if (comp_vld_reg[a_reg]) begin
                    plst_next = 1'b1;
                    pcyc_next = comp_rdata[NODE_W];
                    pid_next  = comp_rdata[NODE_W-1:0];
                end
                state_next = S_EMIT;
            end
            S_OUTER: begin
                if (v_reg > {1'b0, nc_reg}) begin
                    state_next = S_EMIT;
                end else if (node_vld_reg[v_reg[NODE_W-1:0]]) begin
                    v_next = v_reg + 1'b1;
                end else begin
                    w_next     = v_reg[NODE_W-1:0];
                    state_next = S_ENTER;
                end
            end
            S_ENTER: begin
                node_we  = 1'b1;
                path_we  = 1'b1;
                bound_we = 1'b1;
                frame_we = (fp_reg != '0);
                node_vld_next[w_reg] = 1'b1;
                sp_next = sp_reg + 1'b1;
                bp_next = bp_reg + 1'b1;
                fp_next = fp_reg + 1'b1;
                state_next = S_ENT2;
            end
            S_ENT2: begin
                top_node_next = w_reg;
                top_edge_next = head_vld_reg[w_reg] ? head_rdata : EDGE_NULL;
                state_next    = S_LOOP;
            end
            S_LOOP: begin
                if (fp_reg == '0) begin
                    v_next     = v_reg + 1'b1;
                    state_next = S_OUTER;
                end else if (!top_edge_reg[EADDR_W]) begin
                    state_next = S_EDGE2;
                end else begin
                    fp_next    = fp_reg - 1'b1;
                    state_next = S_POP2;
                end
            end
            S_EDGE2: begin
                top_edge_next = edge_rdata[EDGE_W-1:NODE_W];
                if (!in_range(tgt, nc_reg)) begin
                    state_next = S_LOOP;
                end else if (!node_vld_reg[tgt]) begin
                    w_next     = tgt;
                    state_next = S_ENTER;
                end else begin
                    node_raddr = tgt;
                    state_next = S_NODE2;
                end
            end
            S_NODE2: begin
                ot_next    = node_rdata[NODE_W-1:0];
                state_next = node_rdata[NODE_W] ? S_LOOP : S_BPOP;
            end
            S_BPOP: begin
                state_next = (bp_reg == '0) ? S_LOOP : S_BPOP2;
            end
            S_BPOP2: begin
                if (ot_reg < bound_rdata) begin
                    bp_next    = bp_reg - 1'b1;
                    state_next = S_BPOP;
                end else begin
                    state_next = S_LOOP;
                end
            end
            S_POP2: begin
                if (fp_reg != '0) begin
                    top_node_next = frame_rdata[FRAME_W-1:EPTR_W];
                    top_edge_next = frame_rdata[EPTR_W-1:0];
                end
                if (bp_reg == '0 || bound_rdata != node_rdata[NODE_W-1:0]) begin
                    state_next = S_LOOP;
                end else begin
                    bp_next    = bp_reg - 1'b1;
                    base_next  = node_rdata[NODE_W-1:0];
                    i_next     = {1'b0, node_rdata[NODE_W-1:0]};
                    cyc_next   = (size > CNT_W'(1));
                    keep_next  = (size > CNT_W'(1)) || allc_reg;
                    state_next = S_CLRD;
                end
            end
            S_CLRD: begin
                if (i_reg == sp_reg) begin
                    sp_next = {1'b0, base_reg};
                    if (keep_reg) rec_next = rec_reg + 1'b1;
                    state_next = S_LOOP;
                end else begin
                    state_next = S_CLWR;
                end
            end
            S_CLWR: begin
                node_we    = 1'b1;
                node_waddr = path_rdata;
                node_wdata = {1'b1, i_reg[NODE_W-1:0]};
                if (keep_reg) begin
                    comp_we = 1'b1;
                    comp_vld_next[path_rdata] = 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_CLRD;
            end
            S_EMIT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mst_next   = pst_reg;
                    mcnt_next  = rec_reg;
                    mlst_next  = plst_reg;
                    mcyc_next  = pcyc_reg;
                    mid_next   = pid_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sp_reg       <= '0;
            bp_reg       <= '0;
            fp_reg       <= '0;
            rec_reg      <= '0;
            etot_reg     <= '0;
            head_vld_reg <= '0;
            node_vld_reg <= '0;
            comp_vld_reg <= '0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            bp_reg       <= bp_next;
            fp_reg       <= fp_next;
            rec_reg      <= rec_next;
            etot_reg     <= etot_next;
            head_vld_reg <= head_vld_next;
            node_vld_reg <= node_vld_next;
            comp_vld_reg <= comp_vld_next;
            mv_reg       <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg        <= v_next;
        i_reg        <= i_next;
        w_reg        <= w_next;
        ot_reg       <= ot_next;
        base_reg     <= base_next;
        top_node_reg <= top_node_next;
        top_edge_reg <= top_edge_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        keep_reg     <= keep_next;
        cyc_reg      <= cyc_next;
        pst_reg      <= pst_next;
        plst_reg     <= plst_next;
        pcyc_reg     <= pcyc_next;
        pid_reg      <= pid_next;
        mst_reg      <= mst_next;
        mcnt_reg     <= mcnt_next;
        mlst_reg     <= mlst_next;
        mcyc_reg     <= mcyc_next;
        mid_reg      <= mid_next;
    end

    assign m_valid           = mv_reg;
    assign m_status          = mst_reg;
    assign m_component_count = mcnt_reg;
    assign m_node_listed     = mlst_reg;
    assign m_node_cyclic     = mcyc_reg;
    assign m_component_id    = mid_reg;

    `SCF_ASSERT(a_bound_below_path, aclk, aresetn, bp_reg <= sp_reg)
    `SCF_ASSERT(a_frame_below_path, aclk, aresetn, fp_reg <= sp_reg)
    `SCF_ASSERT(a_edge_total_max, aclk, aresetn, etot_reg <= EPTR_W'(MAX_EDGES))
    `SCF_ASSERT_NEXT(a_emit_to_idle, aclk, aresetn, state_reg == S_EMIT && m_ready, state_reg == S_IDLE && mv_reg)
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the strong component finder. Words are sent on the input
// channel with random gaps, results are taken with random stalls, and each
// result is compared against a software copy of the component search that
// runs as each word is accepted. Node count and the all-components flag are
// set over APB only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import scf_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_CLEAR;
    logic [7:0]  s_node = '0;
    logic [7:0]  s_dest_node = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [8:0]  m_component_count;
    logic        m_node_listed;
    logic        m_node_cyclic;
    logic [7:0]  m_component_id;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [2:0] ADDR_NODE_COUNT = 3'(4 * REG_NODE_COUNT);
    localparam logic [2:0] ADDR_ALL_COMP   = 3'(4 * REG_ALL_COMP);

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] count;
        logic       listed;
        logic       cyclic;
        logic [7:0] id;
    } result_t;

    result_t result_queue[$];
    bit      failed = 1'b0;
    int      cycles = 0;

    // Shadow of the block's graph and search state.
    int unsigned nodes_set, all_set;
    int unsigned head[MAX_NODES];
    int unsigned target[MAX_EDGES];
    int unsigned link[MAX_EDGES];
    int unsigned edges_held;
    int unsigned order[MAX_NODES];
    bit          closed[MAX_NODES];
    int unsigned path[MAX_NODES];
    int unsigned bound[MAX_NODES];
    int unsigned fr_node[MAX_NODES];
    int unsigned fr_edge[MAX_NODES];
    int unsigned comp_of[MAX_NODES];
    bit          listed[MAX_NODES];
    bit          cyclic[MAX_NODES];
    int unsigned comps;
    int unsigned psp, pbp, pfp;

    localparam int unsigned UNSEEN = 32'hFFFF_FFFF;

    strong_component_finder_top dut (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[strong_component_finder_top] ERROR");
            $finish;
        end
    end

    function automatic int unsigned last_node();
        return nodes_set < MAX_NODES ? nodes_set : MAX_NODES - 1;
    endfunction

    function automatic bit node_ok(int unsigned v);
        return v >= 1 && v <= last_node();
    endfunction

    function automatic void drop_components();
        for (int i = 0; i < MAX_NODES; i++) begin
            comp_of[i] = 0;
            listed[i] = 0;
            cyclic[i] = 0;
        end
        comps = 0;
    endfunction

    function automatic void drop_edges();
        for (int i = 0; i < MAX_NODES; i++) head[i] = MAX_EDGES;
        edges_held = 0;
    endfunction

    function automatic void push_node(int unsigned w);
        if (psp >= MAX_NODES || pbp >= MAX_NODES || pfp >= MAX_NODES) return;
        order[w] = psp;
        path[psp++] = w;
        bound[pbp++] = order[w];
        fr_node[pfp] = w;
        fr_edge[pfp] = head[w];
        pfp++;
    endfunction

    function automatic void close_root(int unsigned u);
        int unsigned base, size;
        bit keep;
        base = order[u];
        if (pbp == 0 || bound[pbp - 1] != base) return;
        pbp--;
        if (base > psp) return;
        size = psp - base;
        keep = size > 1 || all_set != 0;
        for (int unsigned i = base; i < psp; i++) begin
            closed[path[i]] = 1;
            if (keep) begin
                comp_of[path[i]] = comps & 8'hFF;
                listed[path[i]] = 1;
                cyclic[path[i]] = size > 1;
            end
        end
        if (keep) comps++;
        psp = base;
    endfunction

    function automatic void find_components();
        int unsigned n, e, t;
        n = last_node();
        for (int i = 0; i < MAX_NODES; i++) begin
            order[i] = UNSEEN;
            closed[i] = 0;
        end
        drop_components();
        psp = 0;
        pbp = 0;
        pfp = 0;
        for (int unsigned v = 1; v <= n; v++) begin
            if (order[v] != UNSEEN) continue;
            push_node(v);
            while (pfp > 0) begin
                e = fr_edge[pfp - 1];
                if (e < MAX_EDGES) begin
                    t = target[e];
                    fr_edge[pfp - 1] = link[e];
                    if (t == 0 || t > n) continue;
                    if (order[t] == UNSEEN) push_node(t);
                    else if (!closed[t])
                        while (pbp > 0 && order[t] < bound[pbp - 1]) pbp--;
                end else begin
                    pfp--;
                    close_root(fr_node[pfp]);
                end
            end
        end
    endfunction

    function automatic result_t predict_word(logic [1:0] act, int unsigned a,
                                             int unsigned b);
        result_t r;
        r = '0;
        case (act)
            ACT_CLEAR: begin
                drop_edges();
                drop_components();
            end
            ACT_ADD: begin
                if (!node_ok(a) || !node_ok(b)) r.status = ST_RANGE;
                else if (edges_held >= MAX_EDGES) r.status = ST_FULL;
                else begin
                    target[edges_held] = b;
                    link[edges_held] = head[a];
                    head[a] = edges_held;
                    edges_held++;
                end
            end
            ACT_COMPUTE: find_components();
            default: begin
                if (!node_ok(a)) r.status = ST_RANGE;
                else if (listed[a]) begin
                    r.listed = 1'b1;
                    r.cyclic = cyclic[a];
                    r.id = comp_of[a][7:0];
                end
            end
        endcase
        r.count = comps[8:0];
        return r;
    endfunction

    task automatic send_word(logic [1:0] act, int unsigned a, int unsigned b);
        int unsigned gap;
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_node <= a[7:0];
        s_dest_node <= b[7:0];
        do @(posedge aclk); while (!s_ready);
        result_queue.insert(result_queue.size(),
                            predict_word(act, a & 32'hFF, b & 32'hFF));
    endtask

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (result_queue.size() == 0) begin
                $error("result word with nothing expected");
                failed = 1'b1;
            end else begin
                result_t e;
                e = result_queue.pop_front();
                if (m_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_status); failed = 1'b1;
                end
                if (m_component_count !== e.count) begin
                    $error("component_count exp %0d got %0d", e.count, m_component_count);
                    failed = 1'b1;
                end
                if (m_node_listed !== e.listed) begin
                    $error("node_listed exp %0d got %0d", e.listed, m_node_listed);
                    failed = 1'b1;
                end
                if (m_node_cyclic !== e.cyclic) begin
                    $error("node_cyclic exp %0d got %0d", e.cyclic, m_node_cyclic);
                    failed = 1'b1;
                end
                if (m_component_id !== e.id) begin
                    $error("component_id exp %0d got %0d", e.id, m_component_id);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int w;
        @(posedge aclk);
        forever begin
            w = $urandom_range(0, 7);
            if (w != 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (result_queue.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_NODE_COUNT) nodes_set = 32'(value[7:0]);
        else all_set = 32'(value[0]);
    endtask

    task automatic set_mode(int unsigned n, int unsigned all);
        write_reg(ADDR_NODE_COUNT, n);
        write_reg(ADDR_ALL_COMP, all);
    endtask

    task automatic query_all();
        for (int v = 0; v <= last_node() + 1 && v < 256; v++)
            send_word(ACT_QUERY, v, $urandom_range(0, 255));
    endtask

    task automatic test_directed();
        set_mode(0, 0);
        send_word(ACT_ADD, 1, 1);
        send_word(ACT_QUERY, 0, 0);
        set_mode(5, 1);
        send_word(ACT_ADD, 1, 2);
        send_word(ACT_ADD, 2, 3);
        send_word(ACT_ADD, 3, 1);
        send_word(ACT_ADD, 4, 4);
        send_word(ACT_ADD, 0, 3);
        send_word(ACT_ADD, 3, 6);
        send_word(ACT_ADD, 255, 255);
        send_word(ACT_COMPUTE, 0, 0);
        query_all();
        set_mode(5, 0);
        send_word(ACT_COMPUTE, 0, 0);
        send_word(ACT_QUERY, 4, 0);
        send_word(ACT_QUERY, 5, 0);
        set_mode(2, 0);
        send_word(ACT_COMPUTE, 0, 0);
        send_word(ACT_QUERY, 1, 0);
        send_word(ACT_CLEAR, 0, 0);
        send_word(ACT_QUERY, 1, 0);
    endtask

    task automatic test_large_graph();
        set_mode(255, 1);
        send_word(ACT_CLEAR, 8'hAA, 8'h55);
        for (int i = 0; i < 80; i++)
            send_word(ACT_ADD, $urandom_range(1, 255), $urandom_range(1, 255));
        send_word(ACT_COMPUTE, 8'hFF, 8'hFF);
        send_word(ACT_QUERY, 255, 0);
        send_word(ACT_QUERY, 1, 0);
        send_word(ACT_CLEAR, 0, 0);
    endtask

    task automatic test_random_graphs();
        int unsigned n, k;
        for (int g = 0; g < 12; g++) begin
            n = $urandom_range(1, 12);
            set_mode(n, $urandom_range(0, 1));
            send_word(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
            k = $urandom_range(0, 2 * n);
            for (int i = 0; i < k; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                              $urandom_range(0, 255));
                else
                    send_word(ACT_ADD, $urandom_range(1, n), $urandom_range(1, n));
            end
            send_word(ACT_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255));
            for (int i = 0; i < 6; i++)
                send_word(ACT_QUERY, $urandom_range(0, n + 1), $urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0) begin
                set_mode($urandom_range(0, n), $urandom_range(0, 1));
                send_word(ACT_COMPUTE, 0, 0);
                send_word(ACT_QUERY, $urandom_range(1, n), 0);
            end
        end
    endtask

    initial begin
        nodes_set = 0;
        all_set = 0;
        drop_edges();
        drop_components();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_large_graph();
        test_random_graphs();
        wait_idle();
        if (!failed) $display("[strong_component_finder_top] OK");
        else $display("[strong_component_finder_top] ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/scf_pkg.sv
rtl/core/strong_component_finder_top.sv
tb/tb_top.sv
